/* hw/rtl/b64d_pkg.sv */
// shared types for the base64 decoder: decoder state and one result word
// no dependencies

package b64d_pkg;

  // one result word as it leaves the block
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic       bad_char;
  } b64d_res_t;

  // running state of the message being decoded
  typedef struct packed {
    logic [17:0] bit_acc;
    logic [1:0]  group_pos;
    logic        stopped;
    logic        failed;
  } b64d_state_t;

  localparam int unsigned MaxResults = 3;

endpackage

/* hw/rtl/b64d_decode.sv */
// combinational step of the base64 decoder: one character, current state in,
// next state and up to three result words out; depends on b64d_pkg

module b64d_decode import b64d_pkg::*; (
  input  logic                 [7:0] char_code,
  input  logic                       end_of_text,
  input  b64d_state_t                state,
  output b64d_state_t                state_nxt,
  output b64d_res_t   [MaxResults-1:0] res,
  output logic                 [1:0] res_cnt
);

  localparam logic [7:0] CharPad  = 8'h3D;
  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharPlus = 8'h2B;
  localparam logic [7:0] CharSlsh = 8'h2F;
  localparam logic [5:0] SxPlus   = 6'd62;
  localparam logic [5:0] SxSlash  = 6'd63;

  localparam b64d_state_t StateClear = '{bit_acc: '0, group_pos: '0, stopped: 1'b0,
                                         failed: 1'b0};
  localparam b64d_res_t   ResNone    = '{data_byte: '0, byte_valid: 1'b0,
                                         end_of_message: 1'b0, bad_char: 1'b0};

  // alphabet lookup: bit 6 set when the character is not in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) v = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    else if (c == CharPlus) v = {1'b0, SxPlus};
    else if (c == CharSlsh) v = {1'b0, SxSlash};
    return v;
  endfunction

  logic [6:0]  sx;
  logic [23:0] word;
  logic [17:0] acc_upd;
  logic [17:0] fl_acc;
  logic [1:0]  fl_pos;
  logic        do_flush;

  assign sx      = sextet_of(char_code);
  assign word    = {state.bit_acc, sx[5:0]};
  assign acc_upd = word[17:0];

  always_comb begin
    state_nxt = state;
    res       = {MaxResults{ResNone}};
    res_cnt   = 2'd0;
    do_flush  = 1'b0;
    fl_acc    = state.bit_acc;
    fl_pos    = state.group_pos;

    // character handling
    if (state.stopped || state.failed) begin
      if (end_of_text) state_nxt = StateClear;
    end else if (char_code == CharPad) begin
      do_flush  = 1'b1;
      state_nxt = StateClear;
      state_nxt.stopped = ~end_of_text;
    end else if (char_code == CharCr || char_code == CharLf) begin
      if (end_of_text) begin
        do_flush  = 1'b1;
        state_nxt = StateClear;
      end
    end else if (sx[6]) begin
      res[0].end_of_message = 1'b1;
      res[0].bad_char       = 1'b1;
      res_cnt   = 2'd1;
      state_nxt = StateClear;
      state_nxt.failed = ~end_of_text;
    end else if (state.group_pos == 2'd3) begin
      res[0] = '{data_byte: word[23:16], byte_valid: 1'b1, end_of_message: 1'b0,
                 bad_char: 1'b0};
      res[1] = '{data_byte: word[15:8], byte_valid: 1'b1, end_of_message: 1'b0,
                 bad_char: 1'b0};
      res[2] = '{data_byte: word[7:0], byte_valid: 1'b1, end_of_message: end_of_text,
                 bad_char: 1'b0};
      res_cnt   = 2'd3;
      state_nxt = StateClear;
    end else begin
      fl_acc = acc_upd;
      fl_pos = state.group_pos + 2'd1;
      state_nxt.bit_acc   = acc_upd;
      state_nxt.group_pos = fl_pos;
      if (end_of_text) begin
        do_flush  = 1'b1;
        state_nxt = StateClear;
      end
    end

    // partial group flush
    if (do_flush) begin
      case (fl_pos)
        2'd2: begin
          res[0] = '{data_byte: fl_acc[11:4], byte_valid: 1'b1, end_of_message: 1'b1,
                     bad_char: 1'b0};
          res_cnt = 2'd1;
        end
        2'd3: begin
          res[0] = '{data_byte: fl_acc[17:10], byte_valid: 1'b1, end_of_message: 1'b0,
                     bad_char: 1'b0};
          res[1] = '{data_byte: fl_acc[9:2], byte_valid: 1'b1, end_of_message: 1'b1,
                     bad_char: 1'b0};
          res_cnt = 2'd2;
        end
        default: begin
          res[0].end_of_message = 1'b1;
          res_cnt = 2'd1;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/base64_decoder_core.sv */
// Streaming Base64 decoder. One character enters per cycle on the in_ stream
// (in_tlast marks the final character of a message); decoded bytes leave one
// word per cycle on the out_ stream while out_tready is high. A character
// that completes a group of four makes three output words and a flush of
// three held values makes two; the input then pauses for every word beyond
// the first while the three-entry result buffer drains. A character that
// makes one word or none does not pause the input. Holding out_tready low
// also stalls the input, since a character is only taken once the buffer
// is empty or its last word leaves in that cycle. CR and LF are skipped; a
// bad character gives one word with bad_char set and the rest of the message
// is dropped; after '=' the rest of the message is dropped. The last word of
// each message carries out_tlast.
// Depends on b64d_pkg and b64d_decode.

module base64_decoder_core import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic [1:0] out_tuser,  // [0] byte_valid, [1] bad_char
  output logic       out_tlast   // end_of_message
);

  b64d_state_t                 state_r, state_nxt, dec_state;
  b64d_res_t [MaxResults-1:0]  buf_r, buf_nxt, dec_res;
  logic [1:0]                  cnt_r, cnt_nxt, dec_cnt;
  logic                        in_acc, out_acc;

  // per-character decode step
  b64d_decode u_decode (
    .char_code   (in_tdata),
    .end_of_text (in_tlast),
    .state       (state_r),
    .state_nxt   (dec_state),
    .res         (dec_res),
    .res_cnt     (dec_cnt)
  );

  // take a character when the buffer is empty or its last word goes out now
  assign in_tready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  // result buffer: load on accept, otherwise shift down on each sent word
  always_comb begin
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    state_nxt = state_r;
    if (in_acc) begin
      buf_nxt   = dec_res;
      cnt_nxt   = dec_cnt;
      state_nxt = dec_state;
    end else if (out_acc) begin
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  // output word
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf_r[0].data_byte;
  assign out_tuser  = {buf_r[0].bad_char, buf_r[0].byte_valid};
  assign out_tlast  = buf_r[0].end_of_message;

endmodule
